FILE: rtl/prt_pkg.sv
// Shared types and constants for the prefix trie route table.
// Holds command/result word formats, function and status codes, control bundles.
// No dependencies.
`default_nettype none

package prt_pkg;

	// Default sizes handed to the top level parameters
	localparam int DEF_NODES       = 256;
	localparam int DEF_MAX_KEY     = 32;
	localparam int DEF_CHAR_KINDS  = 256;
	localparam int DEF_HANDLE_BITS = 32;

	// Entry count saturates at this value
	localparam logic [8:0] COUNT_MAX = 9'h1FF;

	// Function codes carried on every word of a key
	typedef enum logic [2:0] {
		FN_LOOKUP  = 3'd0,
		FN_INSERT  = 3'd1,
		FN_REPLACE = 3'd2,
		FN_DELETE  = 3'd3,
		FN_CLEAR   = 3'd4
	} func_e_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_TOOLONG  = 3'd3,
		ST_FULL     = 3'd4
	} status_e_t;

	// Walk flag bit positions
	localparam int FLAG_MISS = 0;
	localparam int FLAG_LONG = 1;
	localparam int FLAG_FULL = 2;

	// Command word: one key character per word
	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  ch;
		logic        has_char;
		logic        key_end;
		logic [31:0] new_handle;
	} cmd_t;

	// Result word
	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] handle;
		logic [8:0]  entry_count;
	} rsp_t;

	// Child store control
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic sweep_start;
	} child_ctl_t;

	// Handle store control
	typedef struct packed {
		logic rd_en;
		logic rd_fresh;
		logic wr_en;
	} handle_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/prt_child_mem.sv
// Child store of the trie: one entry per (node, character) slot, zero means no child.
// Includes the zeroing sweep run after reset and on clear-all. Uses prt_pkg.
`default_nettype none

module prt_child_mem #(
	parameter int NODES = prt_pkg::DEF_NODES,
	parameter int CHAR_KINDS = prt_pkg::DEF_CHAR_KINDS,
	localparam int NODE_W = $clog2(NODES),
	localparam int ADDR_W = $clog2(NODES) + $clog2(CHAR_KINDS)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire prt_pkg::child_ctl_t ctl,
	input  wire logic [ADDR_W-1:0]  rd_addr,
	input  wire logic [ADDR_W-1:0]  wr_addr,
	input  wire logic [NODE_W-1:0]  wr_data,
	output logic      [NODE_W-1:0]  rd_data,
	output logic                    sweeping
);
	import prt_pkg::*;

	localparam int DEPTH = 1 << ADDR_W;

	logic [NODE_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0] sweep_q;
	logic              sweeping_q;
	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [NODE_W-1:0] wd;

	// Advance the sweep pointer; start a sweep at reset and on request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q    <= '0;
			sweeping_q <= 1'b1;
		end else if (ctl.sweep_start) begin
			sweep_q    <= '0;
			sweeping_q <= 1'b1;
		end else if (sweeping_q) begin
			sweep_q <= sweep_q + 1'b1;
			if (sweep_q == {ADDR_W{1'b1}}) begin
				sweeping_q <= 1'b0;
			end
		end
	end

	// Sweep writes take the port while active
	always_comb begin
		we = sweeping_q | ctl.wr_en;
		wa = sweeping_q ? sweep_q : wr_addr;
		wd = sweeping_q ? '0 : wr_data;
	end

	// Memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign sweeping = sweeping_q;

endmodule

`default_nettype wire

FILE: rtl/prt_handle_mem.sv
// Handle store of the trie: per-node handle memory plus the root handle register.
// Returns the handle of the node last read, masking freshly created nodes. Uses prt_pkg.
`default_nettype none

module prt_handle_mem #(
	parameter int NODES = prt_pkg::DEF_NODES,
	parameter int HANDLE_BITS = prt_pkg::DEF_HANDLE_BITS,
	localparam int NODE_W = $clog2(NODES)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire prt_pkg::handle_ctl_t    ctl,
	input  wire logic [NODE_W-1:0]       rd_node,
	input  wire logic [NODE_W-1:0]       wr_node,
	input  wire logic [HANDLE_BITS-1:0]  wr_data,
	output logic      [HANDLE_BITS-1:0]  cur_handle,
	output logic      [HANDLE_BITS-1:0]  root_handle
);
	import prt_pkg::*;

	logic [HANDLE_BITS-1:0] mem [NODES];
	logic [HANDLE_BITS-1:0] rd_q;
	logic [HANDLE_BITS-1:0] root_q;
	logic [NODE_W-1:0]      node_q;
	logic                   fresh_q;
	logic                   mem_we;

	assign mem_we = ctl.wr_en && (wr_node != '0);

	// Root handle lives in a register so reset clears it at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (ctl.wr_en && (wr_node == '0)) begin
			root_q <= wr_data;
		end
	end

	// Track which node the read data belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q  <= '0;
			fresh_q <= 1'b0;
		end else if (ctl.rd_en) begin
			node_q  <= rd_node;
			fresh_q <= ctl.rd_fresh;
		end
	end

	// Memory for nodes other than the root
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_node] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_node];
		end
	end

	// A node created in the same cycle as its read has no handle yet
	always_comb begin
		if (node_q == '0) begin
			cur_handle = root_q;
		end else if (fresh_q) begin
			cur_handle = '0;
		end else begin
			cur_handle = rd_q;
		end
	end

	assign root_handle = root_q;

endmodule

`default_nettype wire

FILE: rtl/prefix_trie_route_table_unit.sv
// Top level of the prefix trie route table: key walk sequencer and final actions.
// Instantiates prt_child_mem and prt_handle_mem. Uses prt_pkg.
//
//   channel   ports                  handshake
//   command   cmd (cmd_t)            taken at clk rise when start=1 and busy=0
//   result    result (rsp_t)         valid for one cycle while done=1
//
// A character word reads the child store, then steps or allocates in S_PROC.
// A key_end word ends with the final action on the handle store in S_FIN;
// its result shows the cycle after. A word without character or key end stays in S_IDLE.
// Reset and clear-all zero the child store, one entry a cycle, over all
// 2**(clog2(NODES)+clog2(CHAR_KINDS)) entries (65536 by default), busy held high.
// The receiver cannot stall; results are never held.
`default_nettype none

module prefix_trie_route_table_unit #(
	parameter int NODES = prt_pkg::DEF_NODES,
	parameter int MAX_KEY = prt_pkg::DEF_MAX_KEY,
	parameter int CHAR_KINDS = prt_pkg::DEF_CHAR_KINDS,
	parameter int HANDLE_BITS = prt_pkg::DEF_HANDLE_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire prt_pkg::cmd_t cmd,
	output logic               done,
	output prt_pkg::rsp_t      result
);
	import prt_pkg::*;

	localparam int NODE_W = $clog2(NODES);
	localparam int CHAR_W = $clog2(CHAR_KINDS);
	localparam int ADDR_W = NODE_W + CHAR_W;
	localparam int KPOS_W = $clog2(MAX_KEY);
	localparam int HW     = HANDLE_BITS;

	typedef enum logic [3:0] {
		S_CLR  = 4'b0001,
		S_IDLE = 4'b0010,
		S_PROC = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [NODE_W-1:0] walk_node_q;
	logic [HW-1:0]     best_q;
	logic [KPOS_W-1:0] kpos_q;
	logic [2:0]        flags_q;
	logic              pend_q;
	logic [NODE_W:0]   next_free_q;
	logic [8:0]        count_q;
	logic              done_q;
	rsp_t              rsp_q;
	logic [2:0]        func_q;
	logic              key_end_q;
	logic [HW-1:0]     nh_q;
	logic [ADDR_W-1:0] caddr_q;

	logic              accept;
	logic [CHAR_W-1:0] ch_tbl [256];
	logic [CHAR_W-1:0] ch_red;

	child_ctl_t        cctl;
	logic [NODE_W-1:0] child_rd;
	logic              sweeping;
	handle_ctl_t       hctl;
	logic [NODE_W-1:0] h_rd_node;
	logic [NODE_W-1:0] h_wr_node;
	logic [HW-1:0]     h_wr_data;
	logic [HW-1:0]     cur_h;
	logic [HW-1:0]     root_h;

	// Step signals
	logic              long_now;
	logic [KPOS_W-1:0] kpos_n;
	logic [2:0]        flags_a;
	logic [2:0]        flags_p;
	logic              create;
	logic              alloc;
	logic              advance;
	logic [NODE_W-1:0] nxt;
	logic [NODE_W-1:0] walk_node_n;

	// Final action signals
	logic [HW-1:0]     eff_best;
	logic              fin_emit;
	logic              fin_clear;
	logic [2:0]        fin_status;
	logic [HW-1:0]     fin_handle;
	logic [8:0]        cnt_n;
	logic              fin_we;
	logic [HW-1:0]     fin_wd;

	// Reduce the character to its slot within a node row
	for (genvar g = 0; g < 256; g++) begin : g_chtbl
		assign ch_tbl[g] = CHAR_W'(g % CHAR_KINDS);
	end
	assign ch_red = ch_tbl[cmd.ch];

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Walk one character on the child word read in the previous cycle
	always_comb begin
		long_now = (kpos_q >= KPOS_W'(MAX_KEY - 1));
		kpos_n   = long_now ? kpos_q : kpos_q + 1'b1;
		flags_a  = flags_q;
		if (long_now) begin
			flags_a[FLAG_LONG] = 1'b1;
		end
		flags_p = flags_a;
		create  = (func_q == FN_INSERT) || (func_q == FN_REPLACE);
		alloc   = 1'b0;
		nxt     = child_rd;
		if (flags_a == 3'b000 && child_rd == '0) begin
			if (create) begin
				if (next_free_q < (NODE_W + 1)'(NODES)) begin
					alloc = 1'b1;
					nxt   = next_free_q[NODE_W-1:0];
				end else begin
					flags_p[FLAG_FULL] = 1'b1;
				end
			end else begin
				flags_p[FLAG_MISS] = 1'b1;
			end
		end
		advance     = (flags_a == 3'b000) && (child_rd != '0 || alloc);
		walk_node_n = advance ? nxt : walk_node_q;
	end

	// Decide the final action of a key
	always_comb begin
		eff_best   = (pend_q && cur_h != '0) ? cur_h : best_q;
		fin_emit   = (func_q <= FN_CLEAR);
		fin_clear  = (func_q == FN_CLEAR);
		fin_status = ST_OK;
		fin_handle = '0;
		cnt_n      = count_q;
		fin_we     = 1'b0;
		fin_wd     = nh_q;
		if (!fin_emit) begin
			cnt_n = count_q;
		end else if (fin_clear) begin
			cnt_n = '0;
		end else if (flags_q[FLAG_LONG]) begin
			fin_status = ST_TOOLONG;
		end else if (flags_q[FLAG_FULL]) begin
			fin_status = ST_FULL;
		end else if (func_q == FN_LOOKUP) begin
			fin_handle = (eff_best != '0) ? eff_best : root_h;
			fin_status = (fin_handle != '0) ? ST_OK : ST_NOTFOUND;
		end else if (flags_q[FLAG_MISS]) begin
			fin_status = ST_NOTFOUND;
		end else if (func_q == FN_INSERT) begin
			if (cur_h != '0) begin
				fin_status = ST_PRESENT;
			end else if (nh_q != '0) begin
				fin_we = 1'b1;
				if (count_q != COUNT_MAX) begin
					cnt_n = count_q + 1'b1;
				end
			end
		end else if (func_q == FN_REPLACE) begin
			fin_handle = cur_h;
			fin_we     = 1'b1;
			if (cur_h == '0 && nh_q != '0 && count_q != COUNT_MAX) begin
				cnt_n = count_q + 1'b1;
			end
			if (cur_h != '0 && nh_q == '0 && count_q != '0) begin
				cnt_n = count_q - 1'b1;
			end
		end else begin
			if (cur_h == '0) begin
				fin_status = ST_NOTFOUND;
			end else begin
				fin_we = 1'b1;
				fin_wd = '0;
				if (count_q != '0) begin
					cnt_n = count_q - 1'b1;
				end
			end
		end
	end

	// Drive the store ports from the current state
	always_comb begin
		cctl.rd_en       = accept && cmd.has_char;
		cctl.wr_en       = (state_q == S_PROC) && alloc;
		cctl.sweep_start = (state_q == S_FIN) && fin_clear;
		hctl.rd_en       = 1'b0;
		hctl.rd_fresh    = 1'b0;
		hctl.wr_en       = 1'b0;
		h_rd_node        = walk_node_q;
		h_wr_node        = walk_node_q;
		h_wr_data        = fin_wd;
		case (state_q)
			S_IDLE: begin
				hctl.rd_en = accept && !cmd.has_char && cmd.key_end;
			end
			S_PROC: begin
				hctl.rd_en    = 1'b1;
				hctl.rd_fresh = alloc;
				hctl.wr_en    = alloc;
				h_rd_node     = walk_node_n;
				h_wr_node     = nxt;
				h_wr_data     = '0;
			end
			S_FIN: begin
				hctl.wr_en = fin_we;
			end
			default: begin
				hctl.rd_en = 1'b0;
			end
		endcase
	end

	// Sequencer and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			walk_node_q <= '0;
			best_q      <= '0;
			kpos_q      <= '0;
			flags_q     <= '0;
			pend_q      <= 1'b0;
			next_free_q <= (NODE_W + 1)'(1);
			count_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					// fold in the handle of the node reached by the last step
					if (pend_q) begin
						if (cur_h != '0) begin
							best_q <= cur_h;
						end
						pend_q <= 1'b0;
					end
					if (accept) begin
						if (cmd.has_char) begin
							state_q <= S_PROC;
						end else if (cmd.key_end) begin
							state_q <= S_FIN;
						end
					end
				end
				S_PROC: begin
					kpos_q      <= kpos_n;
					flags_q     <= flags_p;
					walk_node_q <= walk_node_n;
					pend_q      <= advance;
					if (alloc) begin
						next_free_q <= next_free_q + 1'b1;
					end
					state_q <= key_end_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					done_q      <= fin_emit;
					count_q     <= cnt_n;
					walk_node_q <= '0;
					best_q      <= '0;
					kpos_q      <= '0;
					flags_q     <= '0;
					pend_q      <= 1'b0;
					if (fin_clear) begin
						next_free_q <= (NODE_W + 1)'(1);
						state_q     <= S_CLR;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_CLR: begin
					if (!sweeping) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLR;
				end
			endcase
		end
	end

	// Capture the accepted word and the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= cmd.func;
			key_end_q <= cmd.key_end;
			nh_q      <= HW'(cmd.new_handle);
			caddr_q   <= {walk_node_q, ch_red};
		end
		if (state_q == S_FIN) begin
			rsp_q.status      <= fin_status;
			rsp_q.handle      <= 32'(fin_handle);
			rsp_q.entry_count <= cnt_n;
		end
	end

	prt_child_mem #(
		.NODES      (NODES),
		.CHAR_KINDS (CHAR_KINDS)
	) u_child (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (cctl),
		.rd_addr  ({walk_node_q, ch_red}),
		.wr_addr  (caddr_q),
		.wr_data  (nxt),
		.rd_data  (child_rd),
		.sweeping (sweeping)
	);

	prt_handle_mem #(
		.NODES       (NODES),
		.HANDLE_BITS (HANDLE_BITS)
	) u_handle (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (hctl),
		.rd_node     (h_rd_node),
		.wr_node     (h_wr_node),
		.wr_data     (h_wr_data),
		.cur_handle  (cur_h),
		.root_handle (root_h)
	);

	assign done   = done_q;
	assign result = rsp_q;

endmodule

`default_nettype wire
